// ----- rtl/core/mimw_pkg.sv -----
package mimw_pkg;

    // Number format and fold limit.
    localparam int FRAC_BITS = 16;
    localparam int MAX_FOLDS = 4;

    // Field widths.
    localparam int COORD_W = 32;
    localparam int LEN_W   = 31;
    localparam int DIFF_W  = COORD_W + 1;

    // The x accumulator collects the initial difference plus up to 2*MAX_FOLDS
    // folds per axis, each at most 2^31 in magnitude.
    localparam int ACC_W = COORD_W + $clog2(6 * MAX_FOLDS + 2) + 1;

    localparam int FOLD_CNT_W = $clog2(MAX_FOLDS + 1);

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port.
    localparam int CFG_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_TILTED_BOX = 3'd0;
    localparam reg_idx_t REG_BOX_LEN_X  = 3'd1;
    localparam reg_idx_t REG_BOX_LEN_Y  = 3'd2;
    localparam reg_idx_t REG_BOX_LEN_Z  = 3'd3;
    localparam reg_idx_t REG_TILT_XY    = 3'd4;
    localparam reg_idx_t REG_TILT_XZ    = 3'd5;
    localparam reg_idx_t REG_TILT_YZ    = 3'd6;

    // One classified item: the reference and the raw difference.
    typedef struct packed {
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
        logic signed [COORD_W-1:0] ref_z;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
        logic signed [DIFF_W-1:0]  dz;
    } item_t;

    // Box seen by the fold engine; tilts are already zero in orthogonal mode.
    typedef struct packed {
        logic [LEN_W-1:0]          len_x;
        logic [LEN_W-1:0]          len_y;
        logic [LEN_W-1:0]          len_z;
        logic signed [COORD_W-1:0] t_xy;
        logic signed [COORD_W-1:0] t_xz;
        logic signed [COORD_W-1:0] t_yz;
    } box_cfg_t;

    // Handshake between the front and the queue.
    typedef struct packed {
        logic  wr_en;
        item_t item;
    } queue_wr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_DONE
    } back_state_t;

    typedef enum logic [2:0] {
        PH_Z_UP,
        PH_Z_DN,
        PH_Y_UP,
        PH_Y_DN,
        PH_X_UP,
        PH_X_DN
    } phase_t;

endpackage

// ----- rtl/core/mimw_front.sv -----
module mimw_front (
    input  logic                           push,
    output logic                           full,
    input  logic signed [31:0]             pos_x,
    input  logic signed [31:0]             pos_y,
    input  logic signed [31:0]             pos_z,
    input  logic signed [31:0]             ref_x,
    input  logic signed [31:0]             ref_y,
    input  logic signed [31:0]             ref_z,
    input  logic                           q_full,
    output mimw_pkg::queue_wr_t            q_wr
);
    import mimw_pkg::*;

    // A transfer happens whenever push is high and the queue has room.
    assign full     = q_full;
    assign q_wr.wr_en = push & ~q_full;

    // Keep the reference and form the exact difference.
    assign q_wr.item.ref_x = ref_x;
    assign q_wr.item.ref_y = ref_y;
    assign q_wr.item.ref_z = ref_z;
    assign q_wr.item.dx = {pos_x[COORD_W-1], pos_x} - {ref_x[COORD_W-1], ref_x};
    assign q_wr.item.dy = {pos_y[COORD_W-1], pos_y} - {ref_y[COORD_W-1], ref_y};
    assign q_wr.item.dz = {pos_z[COORD_W-1], pos_z} - {ref_z[COORD_W-1], ref_z};

endmodule

// ----- rtl/core/mimw_queue.sv -----
module mimw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  mimw_pkg::queue_wr_t wr,
    output logic                q_full,
    input  logic                rd_en,
    output mimw_pkg::item_t     rd_item,
    output logic                not_empty
);
    import mimw_pkg::*;

    item_t             entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr;
    logic              do_rd;

    assign q_full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_item   = entries_reg[rd_ptr_reg];

    assign do_wr = wr.wr_en & ~q_full;
    assign do_rd = rd_en & not_empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr.item;
        end
    end

endmodule

// ----- rtl/core/mimw_back.sv -----
module mimw_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mimw_pkg::box_cfg_t     box,
    input  logic                   q_not_empty,
    input  mimw_pkg::item_t        q_item,
    output logic                   q_rd_en,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [31:0]     wrapped_x,
    output logic signed [31:0]     wrapped_y,
    output logic signed [31:0]     wrapped_z,
    output logic                   not_settled
);
    import mimw_pkg::*;

    back_state_t               state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [FOLD_CNT_W-1:0]     cnt_reg, cnt_next;
    logic                      bad_reg, bad_next;
    logic signed [COORD_W-1:0] rx_reg, rx_next;
    logic signed [COORD_W-1:0] ry_reg, ry_next;
    logic signed [COORD_W-1:0] rz_reg, rz_next;
    logic signed [ACC_W-1:0]   ax_reg, ax_next;
    logic signed [ACC_W-1:0]   ay_reg, ay_next;
    logic signed [ACC_W-1:0]   az_reg, az_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [COORD_W-1:0] wx_reg, wx_next;
    logic signed [COORD_W-1:0] wy_reg, wy_next;
    logic signed [COORD_W-1:0] wz_reg, wz_next;
    logic                      ns_reg, ns_next;

    logic signed [ACC_W-1:0]   cur;
    logic [LEN_W-1:0]          len;
    logic signed [COORD_W-1:0] ta;
    logic signed [COORD_W-1:0] tb;
    logic                      going_up;
    logic signed [ACC_W:0]     cur_dbl;
    logic signed [ACC_W:0]     len_ext;
    logic                      cond;
    logic signed [ACC_W-1:0]   step_main;
    logic signed [ACC_W-1:0]   step_a;
    logic signed [ACC_W-1:0]   step_b;
    logic signed [ACC_W-1:0]   main_new;
    logic signed [ACC_W-1:0]   x_new;
    logic signed [ACC_W-1:0]   y_new;

    // Saturate reference plus folded difference to the coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_sum(
        input logic signed [COORD_W-1:0] r,
        input logic signed [ACC_W-1:0]   d
    );
        logic signed [ACC_W:0] s;
        begin
            s = {{(ACC_W + 1 - COORD_W){r[COORD_W-1]}}, r} + {d[ACC_W-1], d};
            if (s > $signed({{(ACC_W + 1 - COORD_W){1'b0}}, 1'b0, {(COORD_W - 1){1'b1}}}))
            begin
                sat_sum = {1'b0, {(COORD_W - 1){1'b1}}};
            end
            else if (s < $signed({{(ACC_W + 1 - COORD_W){1'b1}}, 1'b1, {(COORD_W - 1){1'b0}}}))
            begin
                sat_sum = {1'b1, {(COORD_W - 1){1'b0}}};
            end
            else
            begin
                sat_sum = s[COORD_W-1:0];
            end
        end
    endfunction

    // Pick the axis under work and its carried tilts.
    always_comb
    begin
        cur      = az_reg;
        len      = box.len_z;
        ta       = box.t_xz;
        tb       = box.t_yz;
        going_up = 1'b1;
        unique case (phase_reg)
            PH_Z_UP, PH_Z_DN:
            begin
                cur = az_reg;
                len = box.len_z;
                ta  = box.t_xz;
                tb  = box.t_yz;
            end
            PH_Y_UP, PH_Y_DN:
            begin
                cur = ay_reg;
                len = box.len_y;
                ta  = box.t_xy;
                tb  = '0;
            end
            PH_X_UP, PH_X_DN:
            begin
                cur = ax_reg;
                len = box.len_x;
                ta  = '0;
                tb  = '0;
            end
            default:
            begin
                cur = az_reg;
            end
        endcase
        going_up = (phase_reg == PH_Z_UP) || (phase_reg == PH_Y_UP) || (phase_reg == PH_X_UP);
    end

    // Half-box tests done exactly on the doubled value.
    assign cur_dbl = {cur, 1'b0};
    assign len_ext = $signed({{(ACC_W + 1 - LEN_W){1'b0}}, len});
    assign cond    = going_up ? (cur_dbl >= len_ext) : (cur_dbl < -len_ext);

    // One fold: move the axis by a box length and the lower axes by the tilts.
    assign step_main = $signed({{(ACC_W - LEN_W){1'b0}}, len});
    assign step_a    = {{(ACC_W - COORD_W){ta[COORD_W-1]}}, ta};
    assign step_b    = {{(ACC_W - COORD_W){tb[COORD_W-1]}}, tb};
    assign main_new  = going_up ? cur - step_main : cur + step_main;
    assign x_new     = going_up ? ax_reg - step_a : ax_reg + step_a;
    assign y_new     = going_up ? ay_reg - step_b : ay_reg + step_b;

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        bad_next       = bad_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        rz_next        = rz_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        az_next        = az_reg;
        out_valid_next = out_valid_reg;
        wx_next        = wx_reg;
        wy_next        = wy_reg;
        wz_next        = wz_reg;
        ns_next        = ns_reg;
        q_rd_en        = 1'b0;

        // A transfer on the result side frees the output register.
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_rd_en    = 1'b1;
                    rx_next    = q_item.ref_x;
                    ry_next    = q_item.ref_y;
                    rz_next    = q_item.ref_z;
                    ax_next    = {{(ACC_W - DIFF_W){q_item.dx[DIFF_W-1]}}, q_item.dx};
                    ay_next    = {{(ACC_W - DIFF_W){q_item.dy[DIFF_W-1]}}, q_item.dy};
                    az_next    = {{(ACC_W - DIFF_W){q_item.dz[DIFF_W-1]}}, q_item.dz};
                    bad_next   = 1'b0;
                    cnt_next   = '0;
                    phase_next = PH_Z_UP;
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (cond && (cnt_reg != FOLD_CNT_W'(MAX_FOLDS)))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    unique case (phase_reg)
                        PH_Z_UP, PH_Z_DN:
                        begin
                            az_next = main_new;
                            ax_next = x_new;
                            ay_next = y_new;
                        end
                        PH_Y_UP, PH_Y_DN:
                        begin
                            ay_next = main_new;
                            ax_next = x_new;
                        end
                        PH_X_UP, PH_X_DN:
                        begin
                            ax_next = main_new;
                        end
                        default:
                        begin
                            ax_next = ax_reg;
                        end
                    endcase
                end
                else
                begin
                    // Fold limit reached with the condition still true.
                    if (cond)
                    begin
                        bad_next = 1'b1;
                    end
                    cnt_next = '0;
                    unique case (phase_reg)
                        PH_Z_UP: phase_next = PH_Z_DN;
                        PH_Z_DN: phase_next = PH_Y_UP;
                        PH_Y_UP: phase_next = PH_Y_DN;
                        PH_Y_DN: phase_next = PH_X_UP;
                        PH_X_UP: phase_next = PH_X_DN;
                        PH_X_DN: state_next = ST_DONE;
                        default: phase_next = PH_Z_UP;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    wx_next        = sat_sum(rx_reg, ax_reg);
                    wy_next        = sat_sum(ry_reg, ay_reg);
                    wz_next        = sat_sum(rz_reg, az_reg);
                    ns_next        = bad_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_Z_UP;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        bad_reg <= bad_next;
        rx_reg  <= rx_next;
        ry_reg  <= ry_next;
        rz_reg  <= rz_next;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        az_reg  <= az_next;
        wx_reg  <= wx_next;
        wy_reg  <= wy_next;
        wz_reg  <= wz_next;
        ns_reg  <= ns_next;
    end

    assign empty       = ~out_valid_reg;
    assign wrapped_x   = wx_reg;
    assign wrapped_y   = wy_reg;
    assign wrapped_z   = wz_reg;
    assign not_settled = ns_reg;

endmodule

// ----- rtl/core/minimum_image_wrap_core.sv -----
// Items pass through the queue, the fold sequencer and the output register;
// an item needs from 0 to 6 * MAX_FOLDS folds. The fold sequencer takes one
// item at a time and does one fold or one axis-direction check per cycle; it
// holds a finished item while the output register is full and not popped.
// Reset: rst_n clears the queue, the sequencer and the output register at once;
// the box registers return to orthogonal mode, unit lengths and zero tilts.
module minimum_image_wrap_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic signed [31:0]     pos_x,
    input  logic signed [31:0]     pos_y,
    input  logic signed [31:0]     pos_z,
    input  logic signed [31:0]     ref_x,
    input  logic signed [31:0]     ref_y,
    input  logic signed [31:0]     ref_z,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [31:0]     wrapped_x,
    output logic signed [31:0]     wrapped_y,
    output logic signed [31:0]     wrapped_z,
    output logic                   not_settled,
    input  logic                   wr_en,
    input  mimw_pkg::reg_idx_t     wr_index,
    input  logic [mimw_pkg::CFG_DATA_W-1:0] wr_data
);
    import mimw_pkg::*;

    logic                      tilted_reg;
    logic [LEN_W-1:0]          len_x_reg;
    logic [LEN_W-1:0]          len_y_reg;
    logic [LEN_W-1:0]          len_z_reg;
    logic signed [COORD_W-1:0] tilt_xy_reg;
    logic signed [COORD_W-1:0] tilt_xz_reg;
    logic signed [COORD_W-1:0] tilt_yz_reg;

    box_cfg_t  box;
    queue_wr_t q_wr;
    logic      q_full;
    logic      q_rd_en;
    logic      q_not_empty;
    item_t     q_item;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilted_reg  <= 1'b0;
            len_x_reg   <= LEN_W'(1) << FRAC_BITS;
            len_y_reg   <= LEN_W'(1) << FRAC_BITS;
            len_z_reg   <= LEN_W'(1) << FRAC_BITS;
            tilt_xy_reg <= '0;
            tilt_xz_reg <= '0;
            tilt_yz_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_TILTED_BOX: tilted_reg  <= wr_data[0];
                REG_BOX_LEN_X:  len_x_reg   <= wr_data[LEN_W-1:0];
                REG_BOX_LEN_Y:  len_y_reg   <= wr_data[LEN_W-1:0];
                REG_BOX_LEN_Z:  len_z_reg   <= wr_data[LEN_W-1:0];
                REG_TILT_XY:    tilt_xy_reg <= $signed(wr_data[COORD_W-1:0]);
                REG_TILT_XZ:    tilt_xz_reg <= $signed(wr_data[COORD_W-1:0]);
                REG_TILT_YZ:    tilt_yz_reg <= $signed(wr_data[COORD_W-1:0]);
                default:        tilted_reg  <= tilted_reg;
            endcase
        end
    end

    // Orthogonal mode folds with all tilts taken as zero.
    assign box.len_x = len_x_reg;
    assign box.len_y = len_y_reg;
    assign box.len_z = len_z_reg;
    assign box.t_xy  = tilted_reg ? tilt_xy_reg : '0;
    assign box.t_xz  = tilted_reg ? tilt_xz_reg : '0;
    assign box.t_yz  = tilted_reg ? tilt_yz_reg : '0;

    mimw_front u_front (
        .push   (push),
        .full   (full),
        .pos_x  (pos_x),
        .pos_y  (pos_y),
        .pos_z  (pos_z),
        .ref_x  (ref_x),
        .ref_y  (ref_y),
        .ref_z  (ref_z),
        .q_full (q_full),
        .q_wr   (q_wr)
    );

    mimw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (q_wr),
        .q_full    (q_full),
        .rd_en     (q_rd_en),
        .rd_item   (q_item),
        .not_empty (q_not_empty)
    );

    mimw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .box         (box),
        .q_not_empty (q_not_empty),
        .q_item      (q_item),
        .q_rd_en     (q_rd_en),
        .empty       (empty),
        .pop         (pop),
        .wrapped_x   (wrapped_x),
        .wrapped_y   (wrapped_y),
        .wrapped_z   (wrapped_z),
        .not_settled (not_settled)
    );

endmodule
